[rtl/positional_insert_erase_array_assert.svh]
// Assertion macros for the checker module.
`ifndef POSITIONAL_INSERT_ERASE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_ERASE_ARRAY_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define PIEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every clock edge, reset included.
`define PIEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/piea_pkg.sv]
package piea_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int VAL_W  = 32;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths
  localparam int ACT_W = 3;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  // Stream word layouts
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = ACT_W;
  localparam int OUT_TDATA_W = 48;

  // Actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRINT  = 3'd4;

  // Result status
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

[rtl/piea_ram.sv]
module piea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/positional_insert_erase_array.sv]
// Bounded ordered array of signed 32-bit words held in one 64-entry RAM.
// Input stream: one word per action. in_tuser carries the action (insert,
// erase, get, set, print), in_tdata the position, erase count and value,
// in_tlast marks the final element of an insert run.
// Output stream: one word per result, carrying the element read (get,
// print), the element count, the capacity and a status; out_tuser flags a
// word that holds an element, out_tlast marks the final result of an action.
// Set, get, failed actions and erase of a tail run go straight to the
// result; insert at the end first writes the element; an insert or erase
// inside the array first moves the elements above the position, one
// element per cycle through the single RAM read and write ports; print
// reads and sends each element in turn. The next word can be taken in the
// cycle after the result loads; a new action is not taken before the last
// one is through.
// in_tready is high only while no action is in progress; a result held in
// the output register does not block the next action from being taken.
// When the receiver stalls, the output word holds and the block waits
// before loading the next result.
// Reset (synchronous, rst_n low) empties the array and sets capacity to
// one; RAM contents are not cleared, and no clearing pass is needed.
module positional_insert_erase_array (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [6:0] position, [13:7] count, [45:14] element_value, [47:46] zero
  input  logic [piea_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] action
  input  logic [piea_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] read_value, [38:32] element_count, [45:39] allocated_capacity,
  // [47:46] status
  output logic [piea_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] has_value
  output logic                              out_tuser,
  output logic                              out_tlast
);

  import piea_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOVE   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;
  localparam logic [2:0] S_PR_RD  = 3'd5;
  localparam logic [2:0] S_PR_OUT = 3'd6;

  // Unpack the input word
  logic [ACT_W-1:0] in_action;
  logic [POS_W-1:0] in_pos;
  logic [CNT_W-1:0] in_cnt;
  logic [VAL_W-1:0] in_val;

  assign in_action = in_tuser[ACT_W-1:0];
  assign in_pos    = in_tdata[6:0];
  assign in_cnt    = in_tdata[13:7];
  assign in_val    = in_tdata[45:14];

  // Control and item state
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              run_end_r, run_end_nxt;
  logic              ins_r, ins_nxt;
  logic              up_r, up_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [ADDR_W-1:0] end_idx_r, end_idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic              res_rd_r, res_rd_nxt;

  // Output register
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_has_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [CNT_W-1:0]  out_cap_r;
  logic [ST_W-1:0]   out_st_r;
  logic              out_last_r;

  logic              out_load;
  logic [VAL_W-1:0]  load_val;
  logic              load_has;
  logic [ST_W-1:0]   load_st;
  logic              load_last;
  logic              slot_free;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Helpers
  logic [CNT_W:0]    erase_end;
  logic [CNT_W:0]    cap_dbl;
  logic [CNT_W-1:0]  count_inc;
  logic [ADDR_W-1:0] last_idx;

  assign erase_end = {1'b0, in_pos} + {1'b0, in_cnt};
  assign count_inc = count_r + 1'b1;
  assign cap_dbl   = {cap_r, 1'b0};
  assign last_idx  = ADDR_W'(count_r - 1'b1);
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  piea_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    run_end_nxt = run_end_r;
    ins_nxt     = ins_r;
    up_nxt      = up_r;
    pend_nxt    = pend_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    end_idx_nxt = end_idx_r;
    count_nxt   = count_r;
    cap_nxt     = cap_r;
    res_st_nxt  = res_st_r;
    res_rd_nxt  = res_rd_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_r;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_r;
    out_load    = 1'b0;
    load_val    = '0;
    load_has    = 1'b0;
    load_st     = ST_OK;
    load_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pos_nxt     = in_pos[ADDR_W-1:0];
          cnt_nxt     = in_cnt;
          val_nxt     = in_val;
          run_end_nxt = in_tlast;
          res_rd_nxt  = 1'b0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_RESP;
          unique case (in_action)
            ACT_INSERT: begin
              if (in_pos > count_r) begin
                res_st_nxt = ST_BAD;
              end else if (count_r >= CNT_W'(DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else if (in_pos == count_r) begin
                state_nxt = S_PUT;
              end else begin
                // shift [pos, count) up by one, top element first
                ins_nxt     = 1'b1;
                up_nxt      = 1'b0;
                pend_nxt    = 1'b0;
                rd_idx_nxt  = last_idx;
                end_idx_nxt = in_pos[ADDR_W-1:0];
                wr_idx_nxt  = count_r[ADDR_W-1:0];
                state_nxt   = S_MOVE;
              end
            end
            ACT_ERASE: begin
              if (erase_end > {1'b0, count_r}) begin
                res_st_nxt = ST_BAD;
              end else if (erase_end == {1'b0, count_r}) begin
                count_nxt = count_r - in_cnt;
              end else begin
                // pull [pos + count, size) down, lowest element first
                ins_nxt     = 1'b0;
                up_nxt      = 1'b1;
                pend_nxt    = 1'b0;
                rd_idx_nxt  = erase_end[ADDR_W-1:0];
                end_idx_nxt = last_idx;
                wr_idx_nxt  = in_pos[ADDR_W-1:0];
                state_nxt   = S_MOVE;
              end
            end
            ACT_GET: begin
              if (in_pos >= count_r) begin
                res_st_nxt = ST_BAD;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = in_pos[ADDR_W-1:0];
                res_rd_nxt = 1'b1;
              end
            end
            ACT_SET: begin
              if (in_pos >= count_r) begin
                res_st_nxt = ST_BAD;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = in_pos[ADDR_W-1:0];
                ram_wdata = in_val;
              end
            end
            ACT_PRINT: begin
              if (count_r != '0) begin
                rd_idx_nxt = '0;
                state_nxt  = S_PR_RD;
              end
            end
            default: begin
              res_st_nxt = ST_BAD;
            end
          endcase
        end
      end

      S_MOVE: begin
        // read one element ahead, write the one read last cycle
        ram_re   = 1'b1;
        pend_nxt = 1'b1;
        if (pend_r) begin
          ram_we     = 1'b1;
          wr_idx_nxt = up_r ? wr_idx_r + 1'b1 : wr_idx_r - 1'b1;
        end
        if (rd_idx_r == end_idx_r) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = up_r ? rd_idx_r + 1'b1 : rd_idx_r - 1'b1;
        end
      end

      S_DRAIN: begin
        ram_we = 1'b1;
        if (ins_r) begin
          state_nxt = S_PUT;
        end else begin
          count_nxt = count_r - cnt_r;
          state_nxt = S_RESP;
        end
      end

      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_r;
        ram_wdata  = val_r;
        count_nxt  = count_inc;
        // one insert grows the size by one, so at most one doubling
        if (cap_r < count_inc) begin
          cap_nxt = (cap_dbl > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : cap_dbl[CNT_W-1:0];
        end
        state_nxt = run_end_r ? S_RESP : S_IDLE;
      end

      S_RESP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_val  = res_rd_r ? ram_rdata : '0;
          load_has  = res_rd_r;
          load_st   = res_st_r;
          state_nxt = S_IDLE;
        end
      end

      S_PR_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_PR_OUT;
      end

      S_PR_OUT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_val  = ram_rdata;
          load_has  = 1'b1;
          load_last = (rd_idx_r == last_idx);
          if (rd_idx_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
            state_nxt  = S_PR_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CNT_W'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    val_r     <= val_nxt;
    run_end_r <= run_end_nxt;
    ins_r     <= ins_nxt;
    up_r      <= up_nxt;
    rd_idx_r  <= rd_idx_nxt;
    wr_idx_r  <= wr_idx_nxt;
    end_idx_r <= end_idx_nxt;
    res_st_r  <= res_st_nxt;
    res_rd_r  <= res_rd_nxt;
    if (out_load) begin
      out_val_r   <= load_val;
      out_has_r   <= load_has;
      out_count_r <= count_r;
      out_cap_r   <= cap_r;
      out_st_r    <= load_st;
      out_last_r  <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_st_r, out_cap_r, out_count_r, out_val_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/piea_checker.sv]
`include "positional_insert_erase_array_assert.svh"

module piea_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [piea_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [piea_pkg::IN_TUSER_W-1:0]   in_tuser,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [piea_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);

  import piea_pkg::*;

  logic [CNT_W-1:0] chk_count;
  logic [CNT_W-1:0] chk_cap;
  logic [ST_W-1:0]  chk_st;

  assign chk_count = out_tdata[38:32];
  assign chk_cap   = out_tdata[45:39];
  assign chk_st    = out_tdata[47:46];

  // A stalled result word holds
  `PIEA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Capacity always covers the element count
  `PIEA_ASSERT(a_cap_covers, out_tvalid |-> chk_cap >= chk_count && chk_count <= CNT_W'(DEPTH), "capacity below count")

  // Capacity is a power of two
  `PIEA_ASSERT(a_cap_pow2, out_tvalid |-> $onehot(chk_cap), "capacity not a power of two")

  // An element is only returned with ok status
  `PIEA_ASSERT(a_has_ok, out_tvalid && out_tuser |-> chk_st == ST_OK, "element with bad status")

  // Reset leaves no result pending
  `PIEA_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind positional_insert_erase_array piea_checker u_piea_checker (.*);
